// File: sv/assert_macros.svh
// Assertion helpers used by the parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define FSR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define FSR_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: sv/fsr_pkg.sv
package fsr_pkg;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] HDR_XOR  = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  localparam logic [7:0] TIMEOUT_RESET = 8'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_N     = 3'd1,
    PH_E     = 3'd2,
    PH_R     = 3'd3,
    PH_LEN   = 3'd4,
    PH_TOKEN = 3'd5,
    PH_BODY  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       is_last;
    logic       checksum_ok;
  } res_t;

endpackage

// File: sv/framed_serial_receiver.sv
// Framed serial receiver: takes received bytes and timer ticks (in_tuser set) one item per
// clock while the output is not stalled, finds frames of the form 'U','N','E','R', length, ':'
// and body, and emits each body byte with its index, tlast on the final byte and tuser set
// there when that byte matches the XOR of everything before it in the frame. A tick outside
// hunting counts down from timeout_ticks (loaded by each start byte), abandoning the frame at
// zero. Sustained rate is one item per cycle while out_tready holds; a result passes from the
// input register through the combinational parser outputs into the result register.
module framed_serial_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_byte, byte_index
  output logic        out_tlast,
  output logic        out_tuser,  // checksum_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import fsr_pkg::*;

  logic       in_v_r;
  item_t      item_r;
  logic       adv;
  logic       fire;
  res_t       res;
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic [7:0] out_idx_r;
  logic       out_last_r;
  logic       out_ok_r;
  logic [7:0] timeout_r;

  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op      <= in_tuser;
      item_r.rx_byte <= in_tdata;
    end
  end

  fsr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (item_r),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_byte_r <= res.data_byte;
      out_idx_r  <= res.byte_index;
      out_last_r <= res.is_last;
      out_ok_r   <= res.checksum_ok;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

endmodule

// File: sv/fsr_parser.sv
`include "assert_macros.svh"

module fsr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  fsr_pkg::item_t  item,
  input  logic [7:0]      timeout_ticks,
  output fsr_pkg::res_t   res
);
  import fsr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       last;

  assign last = (remaining_r <= 8'd1);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    pos_nxt       = pos_r;
    ticks_nxt     = ticks_r;
    if (fire) begin
      if (item.op == OP_TICK) begin
        if (phase_r != PH_HUNT) begin
          if (ticks_r <= 8'd1) begin
            ticks_nxt = '0;
            phase_nxt = PH_HUNT;
          end else begin
            ticks_nxt = ticks_r - 8'd1;
          end
        end
      end else begin
        // on a mismatch the byte is looked at again as a start byte
        phase_nxt = PH_HUNT;
        if (item.rx_byte == CH_U) begin
          phase_nxt = PH_N;
          ticks_nxt = timeout_ticks;
        end
        case (phase_r)
          PH_N: begin
            if (item.rx_byte == CH_N) phase_nxt = PH_E;
          end
          PH_E: begin
            if (item.rx_byte == CH_E) phase_nxt = PH_R;
          end
          PH_R: begin
            if (item.rx_byte == CH_R) phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            ticks_nxt     = ticks_r;
            remaining_nxt = item.rx_byte;
            phase_nxt     = (item.rx_byte == 8'd0) ? PH_HUNT : PH_TOKEN;
          end
          PH_TOKEN: begin
            if (item.rx_byte == CH_COLON) begin
              xor_nxt   = HDR_XOR ^ remaining_r;
              pos_nxt   = '0;
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            ticks_nxt = ticks_r;
            pos_nxt   = pos_r + 8'd1;
            if (last) begin
              remaining_nxt = '0;
              phase_nxt     = PH_HUNT;
            end else begin
              xor_nxt       = xor_r ^ item.rx_byte;
              remaining_nxt = remaining_r - 8'd1;
              phase_nxt     = PH_BODY;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res.vld         = fire && (item.op == OP_BYTE) && (phase_r == PH_BODY);
    res.data_byte   = item.rx_byte;
    res.byte_index  = pos_r;
    res.is_last     = last;
    res.checksum_ok = last && (item.rx_byte == xor_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= '0;
      xor_r       <= '0;
      pos_r       <= '0;
      ticks_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      pos_r       <= pos_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  `FSR_ASSERT(a_body_has_count, clk, rst_n, (phase_r == PH_BODY) |-> (remaining_r != 8'd0))
  `FSR_ASSERT(a_last_ends_frame, clk, rst_n, (res.vld && res.is_last) |=> (phase_r == PH_HUNT))
  `FSR_ASSERT(a_ok_only_last, clk, rst_n, res.checksum_ok |-> res.is_last)
  `FSR_ASSERT_NR(a_reset_hunts, clk, !rst_n |=> (phase_r == PH_HUNT))

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import fsr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] idx;
    logic       last;
    logic       ok;
  } beat_t;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
    logic       fixed;
    beat_t      want;
  } dir_row_t;

  localparam int    STALL_LIMIT = 2000;
  localparam int    ITEMS_PER_PHASE = 250;
  localparam beat_t NO_BEAT = '0;

  localparam dir_row_t DIRECTED [28] = '{
    '{OP_TICK, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_U, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_N, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_E, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_R, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h01, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_COLON, 1'b0, NO_BEAT},
    '{OP_BYTE, HDR_XOR ^ 8'h01, 1'b1, '{HDR_XOR ^ 8'h01, 8'd0, 1'b1, 1'b1}},
    // zero length
    '{OP_BYTE, CH_U, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_N, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_E, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_R, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    // header mismatch on a start byte restarts the frame
    '{OP_BYTE, CH_U, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_N, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_U, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_N, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_E, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_R, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h02, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_COLON, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, 8'hFF, 1'b1, '{8'hFF, 8'd1, 1'b1, 1'b0}},
    // timeout abandons the frame
    '{OP_BYTE, CH_U, 1'b0, NO_BEAT},
    '{OP_TICK, 8'hFF, 1'b0, NO_BEAT},
    '{OP_TICK, 8'h00, 1'b0, NO_BEAT},
    '{OP_TICK, 8'h00, 1'b0, NO_BEAT},
    '{OP_BYTE, CH_N, 1'b0, NO_BEAT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  framed_serial_receiver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // frame parser mirror
  phase_t     ph = PH_HUNT;
  logic [7:0] left_cnt = 8'd0;
  logic [7:0] sum_x = 8'd0;
  logic [7:0] pos = 8'd0;
  logic [7:0] ticks = 8'd0;
  logic [7:0] tmo = TIMEOUT_RESET;

  beat_t body_q [$];
  int    errors = 0;
  int    n_sent = 0;
  int    send_idle = 0;
  int    recv_idle = 0;
  int    stall_cnt = 0;

  function automatic void hunt_start(input logic [7:0] b);
    if (b == CH_U) begin
      ph = PH_N;
      ticks = tmo;
    end else begin
      ph = PH_HUNT;
    end
  endfunction

  function automatic bit parse_item(input logic op, input logic [7:0] b, output beat_t r);
    r = '0;
    if (op == OP_TICK) begin
      if (ph != PH_HUNT) begin
        if (ticks <= 8'd1) begin
          ticks = 8'd0;
          ph = PH_HUNT;
        end else begin
          ticks = ticks - 8'd1;
        end
      end
      return 1'b0;
    end
    case (ph)
      PH_N: if (b == CH_N) ph = PH_E; else hunt_start(b);
      PH_E: if (b == CH_E) ph = PH_R; else hunt_start(b);
      PH_R: if (b == CH_R) ph = PH_LEN; else hunt_start(b);
      PH_LEN: begin
        left_cnt = b;
        ph = (b == 8'd0) ? PH_HUNT : PH_TOKEN;
      end
      PH_TOKEN: begin
        if (b == CH_COLON) begin
          sum_x = HDR_XOR ^ left_cnt;
          pos = 8'd0;
          ph = PH_BODY;
        end else begin
          hunt_start(b);
        end
      end
      PH_BODY: begin
        r.data = b;
        r.idx = pos;
        r.last = (left_cnt <= 8'd1);
        r.ok = r.last && (b == sum_x);
        if (r.last) begin
          left_cnt = 8'd0;
          ph = PH_HUNT;
        end else begin
          sum_x = sum_x ^ b;
          left_cnt = left_cnt - 8'd1;
        end
        pos = pos + 8'd1;
        return 1'b1;
      end
      default: hunt_start(b);
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input bit fixed,
                           input beat_t want);
    beat_t r;
    bit    has;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = parse_item(op, b, r);
    if (has || fixed) body_q.push_back(fixed ? want : r);
    n_sent++;
  endtask

  task automatic maybe_tick(input bit clean);
    if (!clean && $urandom_range(99) < 8) send_item(OP_TICK, 8'($urandom), 1'b0, NO_BEAT);
  endtask

  task automatic send_frame(input bit clean, input bit use_len, input logic [7:0] fix_len);
    logic [7:0] hdr [4];
    logic [7:0] len;
    logic [7:0] x;
    logic [7:0] c;
    int         r;
    bit         ticky;
    hdr = '{CH_U, CH_N, CH_E, CH_R};
    ticky = !clean && ($urandom_range(99) < 30);
    r = $urandom_range(99);
    if (use_len) len = fix_len;
    else if (r < 5) len = 8'd0;
    else if (r < 6) len = 8'd255;
    else if (r < 14) len = 8'($urandom_range(7, 40));
    else len = 8'($urandom_range(1, 6));
    for (int i = 0; i < 4; i++) begin
      c = hdr[i];
      if (!clean && $urandom_range(99) < 3) c = 8'($urandom);
      maybe_tick(!ticky);
      send_item(OP_BYTE, c, 1'b0, NO_BEAT);
    end
    maybe_tick(!ticky);
    send_item(OP_BYTE, len, 1'b0, NO_BEAT);
    c = (!clean && $urandom_range(99) < 5) ? 8'($urandom) : CH_COLON;
    maybe_tick(!ticky);
    send_item(OP_BYTE, c, 1'b0, NO_BEAT);
    x = HDR_XOR ^ len;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && $urandom_range(1) == 1) c = x;
      else c = 8'($urandom);
      x = x ^ c;
      maybe_tick(!ticky);
      send_item(OP_BYTE, c, 1'b0, NO_BEAT);
    end
  endtask

  task automatic write_timeout(input logic [7:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (body_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tmo = v;
  endtask

  always @(posedge clk) begin : result_check
    beat_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (body_q.size() == 0) begin
        $error("unexpected item: data_byte %0h byte_index %0d", out_tdata[7:0], out_tdata[15:8]);
        errors++;
      end else begin
        w = body_q.pop_front();
        if (out_tdata[7:0] !== w.data) begin
          $error("data_byte expected %0h actual %0h", w.data, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== w.idx) begin
          $error("byte_index expected %0d actual %0d", w.idx, out_tdata[15:8]);
          errors++;
        end
        if (out_tlast !== w.last) begin
          $error("is_last expected %0b actual %0b", w.last, out_tlast);
          errors++;
        end
        if (out_tuser !== w.ok) begin
          $error("checksum_ok expected %0b actual %0b", w.ok, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] tmo_set [6];
    tmo_set = '{8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd2, 8'($urandom_range(1, 255)),
                8'd255};
    send_idle = 28;
    recv_idle = 68;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 28; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].b, DIRECTED[i].fixed, DIRECTED[i].want);
    end
    for (int p = 0; p < 6; p++) begin
      write_timeout(tmo_set[p]);
      case (p / 2)
        0: begin send_idle = 28; recv_idle = 68; end
        1: begin send_idle = 68; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      n_sent = 0;
      // one full-length frame to reach the top body index
      if (p == 1) send_frame(1'b1, 1'b1, 8'd255);
      while (n_sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(99) < 30) send_item(OP_TICK, 8'($urandom), 1'b0, NO_BEAT);
            else send_item(OP_BYTE, 8'($urandom), 1'b0, NO_BEAT);
          end
        end
        send_frame(1'b0, 1'b0, 8'd0);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (body_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && body_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
